FILE: rtl/core/dtes_pkg.sv
// Shared types, constants and key decoding for the DTMF telephone-event sender.
`default_nettype none

package dtes_pkg;

  // Digit queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // End packets sent per event
  localparam int END_REPEATS = 3;
  localparam int RPT_W       = $clog2(END_REPEATS + 1);

  localparam logic [5:0] MAX_VOLUME = 6'd55;
  localparam logic [7:0] END_FLAG   = 8'h80;
  localparam logic [7:0] EVT_NONE   = 8'd255;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPP     = 2'd0;
  localparam logic [1:0] CFG_MIN_DUR = 2'd1;
  localparam logic [1:0] CFG_GAP     = 2'd2;

  // Configuration reset values
  localparam logic [11:0] SPP_RESET     = 12'd160;
  localparam logic [19:0] MIN_DUR_RESET = 20'd800;
  localparam logic [15:0] GAP_RESET     = 16'd50;

  typedef enum logic [1:0] {
    OP_QUEUE  = 2'd0,
    OP_FRAME  = 2'd1,
    OP_TICK   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_QUEUED   = 3'd0,
    KIND_SKIPPED  = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_AUDIO    = 3'd3,
    KIND_DTMF     = 3'd4,
    KIND_DROPPED  = 3'd5,
    KIND_TICK     = 3'd6
  } kind_t;

  // One stored digit
  typedef struct packed {
    logic [19:0] duration;
    logic [5:0]  volume;
    logic [4:0]  event_code;
  } entry_t;

  // Control broadcast along the cell row
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } chain_ctrl_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  event_code;
    logic [7:0]  volume_byte;
    logic [15:0] duration_field;
    logic        marker;
    logic [11:0] timestamp_advance;
    logic [31:0] frame_timestamp;
    logic        voice_changed;
    logic        voice_active;
  } result_t;

  // ASCII key to telephone-event number, EVT_NONE for a non-key
  function automatic logic [7:0] key_to_event(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] ev;
    lc = c;
    if (c >= "A" && c <= "Z") lc = c + 8'd32;
    case (lc) inside
      ["0":"9"]: ev = lc - "0";
      ["a":"d"]: ev = lc - "a" + 8'd12;
      "*":       ev = 8'd10;
      "#":       ev = 8'd11;
      "r":       ev = 8'd16;
      default:   ev = EVT_NONE;
    endcase
    return ev;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dtes_cell.sv
// One digit queue cell: loads a new digit or takes its neighbor's on a pop.
`default_nettype none

module dtes_cell
  import dtes_pkg::*;
(
  input  wire logic        clk,
  input  wire chain_ctrl_t ctrl,
  input  wire logic        sel,
  input  wire entry_t      from_next,
  output entry_t           q
);

  // Pop moves the row one place toward the head; push fills the tail cell
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      q <= from_next;
    end else if (ctrl.push && sel) begin
      q <= ctrl.entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dtes_chain.sv
// Row of digit cells forming a shifting queue; cell zero is the head.
`default_nettype none

module dtes_chain
  import dtes_pkg::*;
(
  input  wire logic             clk,
  input  wire chain_ctrl_t      ctrl,
  input  wire logic [CNT_W-1:0] fill,
  output entry_t                head
);

  entry_t cells [QUEUE_DEPTH];

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t nbr;
      logic   sel;
      // Last cell refills with a blank entry
      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cells[i+1];
      end
      assign sel = (fill == CNT_W'(i));
      dtes_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .sel       (sel),
        .from_next (nbr),
        .q         (cells[i])
      );
    end
  endgenerate

  assign head = cells[0];

endmodule

`default_nettype wire

FILE: rtl/core/dtmf_telephone_event_sender_core.sv
// Top level of the DTMF telephone-event sender: item decode, state and output buffer.
//
// Takes one item per clock cycle while s_tready is high: every item
// (character, media frame or millisecond tick) updates the sender state,
// and its result is registered into the output buffer. The digit
// queue is a row of 32 cells that shift toward the head on each pop, so
// the head digit is always read from a fixed cell. A two-entry output
// buffer (result register plus skid register) lets the slave side keep
// accepting while one result waits; s_tready drops only when both are full.
// Operation code 3 is accepted and gives no result.
`default_nettype none

module dtmf_telephone_event_sender_core
  import dtes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] char_code, [8] batch_first, [16:9] batch_length,
  // [36:17] duration_samples, [44:37] volume_in, [56:45] frame_samples,
  // [57] voice_flag, [63:58] zero
  input  wire logic [63:0] s_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_tuser,
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] event_code, [15:8] volume_byte, [31:16] duration_field,
  // [32] marker, [44:33] timestamp_advance, [76:45] frame_timestamp,
  // [77] voice_changed, [78] voice_active, [79] zero
  output logic [79:0]      m_tdata,
  // [2:0] kind
  output logic [2:0]       m_tuser
);

  // Configuration registers
  logic [11:0] spp_cfg;
  logic [19:0] min_dur;
  logic [15:0] gap_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      spp_cfg <= SPP_RESET;
      min_dur <= MIN_DUR_RESET;
      gap_cfg <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPP:     spp_cfg <= cfg_data[11:0];
        CFG_MIN_DUR: min_dur <= cfg_data;
        CFG_GAP:     gap_cfg <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  // Input fields
  op_t         op;
  logic [7:0]  char_code;
  logic        batch_first;
  logic [7:0]  batch_length;
  logic [19:0] duration_samples;
  logic [7:0]  volume_in;
  logic [11:0] frame_samples;
  logic        voice_flag;

  assign op               = op_t'(s_tuser);
  assign char_code        = s_tdata[7:0];
  assign batch_first      = s_tdata[8];
  assign batch_length     = s_tdata[16:9];
  assign duration_samples = s_tdata[36:17];
  assign volume_in        = s_tdata[44:37];
  assign frame_samples    = s_tdata[56:45];
  assign voice_flag       = s_tdata[57];

  // Sender state
  logic [CNT_W-1:0] count, count_next;
  logic [21:0]      elapsed, elapsed_next;
  logic             first_sent, first_sent_next;
  logic [RPT_W-1:0] repeats, repeats_next;
  logic [15:0]      gap, gap_next;
  logic [31:0]      ts, ts_next;
  logic             voice_state, voice_state_next;
  logic             refused, refused_next;

  logic accept;
  logic has_res;
  result_t res;
  chain_ctrl_t ctrl;
  entry_t head;

  assign accept = s_tvalid && s_tready;

  dtes_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .fill (count),
    .head (head)
  );

  // Per-item decode and state update
  always_comb begin
    logic [7:0]       code;
    logic [19:0]      req;
    logic [5:0]       vol;
    logic [11:0]      spp;
    logic [11:0]      adv;
    logic [RPT_W:0]   rpt_inc;
    logic             first;

    count_next       = count;
    elapsed_next     = elapsed;
    first_sent_next  = first_sent;
    repeats_next     = repeats;
    gap_next         = gap;
    ts_next          = ts;
    voice_state_next = voice_state;
    refused_next     = refused;

    code    = key_to_event(char_code);
    req     = (duration_samples < min_dur) ? min_dur : duration_samples;
    vol     = (volume_in > {2'b00, MAX_VOLUME}) ? MAX_VOLUME : volume_in[5:0];
    spp     = (spp_cfg == 12'd0) ? 12'd1 : spp_cfg;
    adv     = '0;
    rpt_inc = {1'b0, repeats} + (RPT_W+1)'(1);
    first   = 1'b0;

    ctrl.push             = 1'b0;
    ctrl.pop              = 1'b0;
    ctrl.entry.event_code = code[4:0];
    ctrl.entry.volume     = vol;
    ctrl.entry.duration   = req;

    has_res = 1'b0;
    res     = '0;
    res.frame_timestamp = ts;

    if (accept) begin
      case (op)
        OP_QUEUE: begin
          has_res = 1'b1;
          if (batch_first) begin
            refused_next = (({3'b000, count} + {1'b0, batch_length}) >= 9'(QUEUE_DEPTH));
          end
          if (refused_next) begin
            res.kind = KIND_REJECTED;
          end else if (code == EVT_NONE) begin
            res.kind = KIND_SKIPPED;
          end else if (count >= CNT_W'(QUEUE_DEPTH)) begin
            res.kind = KIND_REJECTED;
          end else begin
            ctrl.push          = 1'b1;
            count_next         = count + CNT_W'(1);
            res.kind           = KIND_QUEUED;
            res.event_code     = code;
            res.volume_byte    = {2'b00, vol};
            res.duration_field = req[15:0];
          end
        end
        OP_TICK: begin
          has_res = 1'b1;
          if (gap != 16'd0) gap_next = gap - 16'd1;
          res.kind = KIND_TICK;
        end
        OP_FRAME: begin
          has_res = 1'b1;
          res.voice_changed = (voice_flag != voice_state);
          voice_state_next  = voice_flag;
          if (count != '0 && gap == 16'd0) begin
            if (elapsed != 22'd0 && !first_sent) begin
              first           = 1'b1;
              first_sent_next = 1'b1;
            end
            res.event_code     = {3'b000, head.event_code};
            res.volume_byte    = {2'b00, head.volume};
            res.duration_field = elapsed[15:0];
            res.marker         = first;
            if (elapsed >= {2'b00, head.duration}) begin
              // End packet; the last repeat pops the digit
              res.volume_byte = res.volume_byte | END_FLAG;
              res.kind        = KIND_DTMF;
              repeats_next    = rpt_inc[RPT_W-1:0];
              if (rpt_inc >= (RPT_W+1)'(END_REPEATS)) begin
                ctrl.pop        = 1'b1;
                count_next      = count - CNT_W'(1);
                elapsed_next    = '0;
                first_sent_next = 1'b0;
                repeats_next    = '0;
                gap_next        = gap_cfg;
                adv             = spp;
              end
            end else begin
              elapsed_next = 22'(elapsed + {10'd0, spp});
              if (elapsed == 22'd0) begin
                // Opening frame of an event sends nothing
                res.kind           = KIND_DROPPED;
                res.event_code     = '0;
                res.volume_byte    = '0;
                res.duration_field = '0;
                res.marker         = 1'b0;
              end else begin
                res.kind = KIND_DTMF;
                adv      = spp;
              end
            end
          end else begin
            res.kind = KIND_AUDIO;
            adv      = frame_samples;
          end
          ts_next = 32'(ts + {20'd0, adv});
        end
        default: ;
      endcase
    end

    res.timestamp_advance = adv;
    res.voice_active      = voice_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      elapsed     <= '0;
      first_sent  <= 1'b0;
      repeats     <= '0;
      gap         <= '0;
      ts          <= '0;
      voice_state <= 1'b0;
      refused     <= 1'b0;
    end else begin
      count       <= count_next;
      elapsed     <= elapsed_next;
      first_sent  <= first_sent_next;
      repeats     <= repeats_next;
      gap         <= gap_next;
      ts          <= ts_next;
      voice_state <= voice_state_next;
      refused     <= refused_next;
    end
  end

  // Output buffer: result register plus skid register
  result_t out_q, skid_q;
  logic    out_valid, skid_valid;
  logic    take;

  assign take     = m_tvalid && m_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (has_res) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) out_q <= skid_q;
    end else if (has_res) begin
      if (!out_valid || take) out_q <= res;
      else skid_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.kind;
  assign m_tdata  = {1'b0, out_q.voice_active, out_q.voice_changed, out_q.frame_timestamp,
                     out_q.timestamp_advance, out_q.marker, out_q.duration_field,
                     out_q.volume_byte, out_q.event_code};

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("digit count beyond queue depth");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without a result in front");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_tready |=> skid_valid && $stable(skid_q))
    else $error("skid entry lost while stalled");

  a_first_elapsed: assert property (@(posedge clk) disable iff (rst)
    first_sent |-> elapsed != 22'd0)
    else $error("first packet flag set with no elapsed time");

  a_repeats_range: assert property (@(posedge clk) disable iff (rst)
    repeats < RPT_W'(END_REPEATS))
    else $error("end repeat count overran");

endmodule

`default_nettype wire

FILE: tb/dtes_sender_checker.sv
// Checker for the DTMF telephone-event sender: tracks the sender state and compares every result.
`timescale 1ns / 1ps

module dtes_sender_checker
  import dtes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          fail_count,
  output int          due_count
);

  // Telephone-event numbers of the non-digit keys
  localparam logic [7:0] EV_STAR   = 8'd10;
  localparam logic [7:0] EV_POUND  = 8'd11;
  localparam logic [7:0] EV_KEY_A  = 8'd12;
  localparam logic [7:0] EV_FLASH  = 8'd16;
  localparam int         PRINT_CAP = 100;

  // Configuration copy
  logic [11:0] pkt_samples;
  logic [19:0] min_samples;
  logic [15:0] gap_ticks;

  // Digit queue and head-of-queue progress
  entry_t      digits [QUEUE_DEPTH];
  logic [4:0]  head_idx;
  logic [4:0]  tail_idx;
  logic [5:0]  queued;
  logic [21:0] elapsed;
  logic        first_sent;
  logic [1:0]  end_sent;
  logic [15:0] gap_left;
  logic [31:0] stamp;
  logic        voice_now;
  logic        refused;

  result_t     results_due [$];
  result_t     seen;
  result_t     want;

  initial fail_count = 0;

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, exp_val));
  endtask

  function automatic logic [7:0] event_of_key(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "d") return c - "a" + EV_KEY_A;
    if (c >= "A" && c <= "D") return c - "A" + EV_KEY_A;
    if (c == "*") return EV_STAR;
    if (c == "#") return EV_POUND;
    if (c == "r" || c == "R") return EV_FLASH;
    return EVT_NONE;
  endfunction

  // Apply one accepted item to the sender state and queue the result it owes
  task automatic step_sender(input op_t op, input logic [63:0] d);
    result_t     r;
    logic [7:0]  code;
    logic [7:0]  blen;
    logic [19:0] dur;
    logic [19:0] req;
    logic [7:0]  vol;
    logic [5:0]  vclamp;
    logic [11:0] fsamp;
    logic [11:0] pkt;
    logic        voice;
    entry_t      head;
    code  = event_of_key(d[7:0]);
    blen  = d[16:9];
    dur   = d[36:17];
    vol   = d[44:37];
    fsamp = d[56:45];
    voice = d[57];
    if (op == OP_UNUSED) return;
    r = '0;
    r.frame_timestamp = stamp;
    pkt = (pkt_samples == '0) ? 12'd1 : pkt_samples;
    case (op)
      OP_QUEUE: begin
        // a string's first character decides whether the whole string is refused
        if (d[8]) refused = (32'(queued) + 32'(blen)) >= QUEUE_DEPTH;
        if (refused) begin
          r.kind = KIND_REJECTED;
        end else if (code == EVT_NONE) begin
          r.kind = KIND_SKIPPED;
        end else if (queued >= QUEUE_DEPTH) begin
          r.kind = KIND_REJECTED;
        end else begin
          req    = (dur < min_samples) ? min_samples : dur;
          vclamp = (vol > MAX_VOLUME) ? MAX_VOLUME : vol[5:0];
          digits[tail_idx] = '{duration: req, volume: vclamp, event_code: code[4:0]};
          tail_idx++;
          queued++;
          r.kind           = KIND_QUEUED;
          r.event_code     = code;
          r.volume_byte    = {2'b00, vclamp};
          r.duration_field = req[15:0];
        end
      end
      OP_TICK: begin
        if (gap_left != '0) gap_left--;
        r.kind = KIND_TICK;
      end
      default: begin
        r.voice_changed = (voice != voice_now);
        voice_now = voice;
        if (queued != '0 && gap_left == '0) begin
          head = digits[head_idx];
          r.event_code     = {3'b000, head.event_code};
          r.volume_byte    = {2'b00, head.volume};
          r.duration_field = elapsed[15:0];
          if (elapsed != '0 && !first_sent) begin
            first_sent = 1'b1;
            r.marker   = 1'b1;
          end
          if (elapsed >= head.duration) begin
            // end packets: only the last one advances and pops the digit
            r.volume_byte = r.volume_byte | END_FLAG;
            r.kind = KIND_DTMF;
            end_sent++;
            if (end_sent >= END_REPEATS) begin
              head_idx++;
              queued--;
              elapsed    = '0;
              first_sent = 1'b0;
              end_sent   = '0;
              gap_left   = gap_ticks;
              r.timestamp_advance = pkt;
            end
          end else if (elapsed == '0) begin
            // first frame of an event is swallowed
            elapsed = elapsed + pkt;
            r.kind           = KIND_DROPPED;
            r.event_code     = '0;
            r.volume_byte    = '0;
            r.duration_field = '0;
            r.marker         = 1'b0;
          end else begin
            elapsed = elapsed + pkt;
            r.kind = KIND_DTMF;
            r.timestamp_advance = pkt;
          end
        end else begin
          r.kind = KIND_AUDIO;
          r.timestamp_advance = fsamp;
        end
        stamp = stamp + r.timestamp_advance;
      end
    endcase
    r.voice_active = voice_now;
    results_due.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pkt_samples = SPP_RESET;
      min_samples = MIN_DUR_RESET;
      gap_ticks   = GAP_RESET;
      head_idx    = '0;
      tail_idx    = '0;
      queued      = '0;
      elapsed     = '0;
      first_sent  = 1'b0;
      end_sent    = '0;
      gap_left    = '0;
      stamp       = '0;
      voice_now   = 1'b0;
      refused     = 1'b0;
      results_due.delete();
    end else begin
      // results leave before this edge's item can have produced one
      if (m_tvalid && m_tready) begin
        seen.kind              = kind_t'(m_tuser);
        seen.event_code        = m_tdata[7:0];
        seen.volume_byte       = m_tdata[15:8];
        seen.duration_field    = m_tdata[31:16];
        seen.marker            = m_tdata[32];
        seen.timestamp_advance = m_tdata[44:33];
        seen.frame_timestamp   = m_tdata[76:45];
        seen.voice_changed     = m_tdata[77];
        seen.voice_active      = m_tdata[78];
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result, kind %0d", m_tuser));
        end else begin
          want = results_due.pop_front();
          check_field("kind", 32'(seen.kind), 32'(want.kind));
          check_field("event_code", 32'(seen.event_code), 32'(want.event_code));
          check_field("volume_byte", 32'(seen.volume_byte), 32'(want.volume_byte));
          check_field("duration_field", 32'(seen.duration_field),
                      32'(want.duration_field));
          check_field("marker", 32'(seen.marker), 32'(want.marker));
          check_field("timestamp_advance", 32'(seen.timestamp_advance),
                      32'(want.timestamp_advance));
          check_field("frame_timestamp", seen.frame_timestamp, want.frame_timestamp);
          check_field("voice_changed", 32'(seen.voice_changed),
                      32'(want.voice_changed));
          check_field("voice_active", 32'(seen.voice_active), 32'(want.voice_active));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPP:     pkt_samples = cfg_data[11:0];
          CFG_MIN_DUR: min_samples = cfg_data;
          CFG_GAP:     gap_ticks   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) step_sender(op_t'(s_tuser), s_tdata);
    end
    due_count <= results_due.size();
  end

endmodule

FILE: tb/dtmf_telephone_event_sender_core_test.sv
// Stimulus and verdict for the DTMF telephone-event sender core.
`timescale 1ns / 1ps

module dtmf_telephone_event_sender_core_test;
  import dtes_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 310;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SPP;
  logic [19:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_QUEUE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;

  int fail_count;
  int due_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int dur_cap = 1500;
  int quiet_cycles = 0;
  logic  frame_voice = 1'b0;
  string key_chars = "0123456789abcdABCD*#rR";

  dtmf_telephone_event_sender_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  dtes_sender_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] pack_item(input logic [7:0] ch, input logic first,
                                            input logic [7:0] blen, input logic [19:0] dur,
                                            input logic [7:0] vol, input logic [11:0] fsamp,
                                            input logic voice);
    return {6'b0, voice, fsamp, vol, dur, blen, first, ch};
  endfunction

  // Offer one item, with random idle cycles ahead of it, and wait until taken
  task automatic send_item(input op_t op, input logic [63:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= payload;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_char(input logic [7:0] ch, input logic first, input logic [7:0] blen,
                           input logic [19:0] dur, input logic [7:0] vol);
    send_item(OP_QUEUE, pack_item(ch, first, blen, dur, vol, 12'($urandom_range(0, 4095)),
                                  1'($urandom_range(0, 1))));
  endtask

  task automatic send_frame(input logic [11:0] fsamp, input logic voice);
    send_item(OP_FRAME, pack_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255)),
                                  20'($urandom_range(0, 20'hFFFFF)),
                                  8'($urandom_range(0, 255)), fsamp, voice));
  endtask

  task automatic send_noise_fields(input op_t op);
    send_item(op, pack_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)), 20'($urandom_range(0, 20'hFFFFF)),
                            8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                            1'($urandom_range(0, 1))));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Let every result drain, then load new settings while the core is quiet
  task automatic drain_and_configure(input logic [11:0] spp, input logic [19:0] min_dur,
                                     input logic [15:0] gap);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_SPP, spp);
    write_reg(CFG_MIN_DUR, min_dur);
    write_reg(CFG_GAP, gap);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_char(output logic [7:0] ch);
    if ($urandom_range(11) == 0) ch = 8'($urandom_range(0, 255));
    else ch = key_chars[$urandom_range(0, key_chars.len() - 1)];
  endtask

  // Mostly well-formed key strings mixed with frames and ticks; some strings
  // understate their length, some are oversized and get refused
  task automatic run_phase(input int n_items);
    int          sent;
    int          sel;
    int          len;
    logic [7:0]  blen;
    logic [19:0] dur;
    logic [7:0]  ch;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        blen = ($urandom_range(4) == 0) ? 8'($urandom_range(0, 255)) : 8'(len);
        // full-range durations only on strings that can never be queued
        if (blen >= QUEUE_DEPTH) dur = 20'($urandom_range(0, 20'hFFFFF));
        else dur = 20'($urandom_range(0, dur_cap));
        for (int i = 0; i < len; i++) begin
          pick_char(ch);
          send_char(ch, i == 0, (i == 0) ? blen : 8'($urandom_range(0, 255)), dur,
                    8'($urandom_range(0, 255)));
          sent++;
        end
      end else if (sel < 70) begin
        if ($urandom_range(9) < 3) frame_voice = ~frame_voice;
        send_frame(12'($urandom_range(0, 4095)), frame_voice);
        sent++;
      end else if (sel < 97) begin
        send_noise_fields(OP_TICK);
        sent++;
      end else if (sel < 99) begin
        // stray character with no string start in front of it
        pick_char(ch);
        send_char(ch, 1'b0, 8'($urandom_range(0, 255)), 20'($urandom_range(0, dur_cap)),
                  8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_noise_fields(OP_UNUSED);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, one full digit from queueing to gap
    send_noise_fields(OP_TICK);
    send_noise_fields(OP_UNUSED);
    send_frame(12'd0, 1'b0);
    send_frame(12'hFFF, 1'b1);
    send_char("x", 1'b1, 8'd3, 20'd0, 8'd0);
    send_char("5", 1'b0, 8'd0, 20'd0, 8'hFF);
    send_char("#", 1'b0, 8'd0, 20'd900, 8'd55);
    send_char("1", 1'b1, 8'hFF, 20'hFFFFF, 8'd0);
    send_char("A", 1'b0, 8'd0, 20'd0, 8'd0);
    send_char("*", 1'b1, 8'd1, 20'd100, 8'd56);
    // dropped first frame, marked packet, packets, three end packets
    repeat (8) send_frame(12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    // gap holds the next digit back
    send_frame(12'($urandom_range(0, 4095)), 1'b1);
    send_noise_fields(OP_TICK);
    send_noise_fields(OP_TICK);

    // Zero packet size, zero minimum, no gap; no idling
    drain_and_configure(12'd0, 20'd0, 16'd0);
    dur_cap = 6;
    run_phase(PHASE_ITEMS);

    drain_and_configure(12'd160, 20'd800, 16'd3);
    dur_cap = 1500;
    send_idle_pct <= 51;
    run_phase(PHASE_ITEMS);

    drain_and_configure(12'hFFF, 20'd20000, 16'd7);
    dur_cap = 30000;
    send_idle_pct  <= 0;
    recv_stall_pct <= 51;
    run_phase(PHASE_ITEMS);

    // Largest minimum duration and gap last: queue mostly stalls here
    drain_and_configure(12'd1234, 20'hFFFFF, 16'hFFFF);
    dur_cap = 1500;
    send_idle_pct  <= 12;
    recv_stall_pct <= 12;
    run_phase(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dtes_pkg.sv
rtl/core/dtes_cell.sv
rtl/core/dtes_chain.sv
rtl/core/dtmf_telephone_event_sender_core.sv
tb/dtes_sender_checker.sv
tb/dtmf_telephone_event_sender_core_test.sv
